// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

  // operation codes
  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_NEG = 3'd4,
    FUNC_CMP = 3'd5
  } func_e;

  // divider remainder width and quotient width
  localparam int unsigned RemW = 49;
  localparam int unsigned QuoW = 17;
  localparam int unsigned DivSteps = QuoW;

  localparam logic signed [33:0] PartMax = 34'sd32767;
  localparam logic signed [33:0] PartMin = -34'sd32768;

  typedef struct packed {
    logic [15:0] val;
    logic        ovf;
  } sat_t;

  // saturate a wide signed value to one 16 bit part
  function automatic sat_t sat16(input logic signed [33:0] x);
    sat_t r;
    if (x > PartMax) begin
      r.val = 16'h7fff;
      r.ovf = 1'b1;
    end else if (x < PartMin) begin
      r.val = 16'h8000;
      r.ovf = 1'b1;
    end else begin
      r.val = x[15:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cau_div.sv =====
module cau_div (
  input  logic                        clk_i,
  input  logic [cau_pkg::RemW-1:0]    num_i,
  input  logic [31:0]                 den_i,
  output logic [cau_pkg::QuoW-1:0]    quo_o
);
  import cau_pkg::*;

  logic [RemW-1:0] rem_q [DivSteps];
  logic [31:0]     den_q [DivSteps];
  logic [QuoW-1:0] quo_q [DivSteps];

  // one restoring step per stage, quotient msb first
  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    localparam int unsigned K = DivSteps - 1 - i;
    logic [RemW-1:0] rem_in;
    logic [31:0]     den_in;
    logic [QuoW-1:0] quo_in;
    logic [RemW-1:0] sub_w;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign sub_w = {{(RemW-32){1'b0}}, den_in} << K;

    always_ff @(posedge clk_i) begin
      den_q[i] <= den_in;
      if (rem_in >= sub_w) begin
        rem_q[i] <= rem_in - sub_w;
        quo_q[i] <= quo_in | (QuoW'(1) << K);
      end else begin
        rem_q[i] <= rem_in;
        quo_q[i] <= quo_in;
      end
    end
  end

  assign quo_o = quo_q[DivSteps-1];

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// complex alu on q8.8 parts: add, subtract, multiply, divide, negate, compare
// every operation takes the same path, through the divider side line, to the valid_o strobe
// throughput: one word per cycle, busy stays low; the 17 step divider pipeline sets depth
// results show for one cycle only, the receiver cannot stall the pipeline
// reset: rst_ni low clears all valid bits at once, words in flight are dropped
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic signed [15:0] a_re_i,
  input  logic signed [15:0] a_im_i,
  input  logic signed [15:0] b_re_i,
  input  logic signed [15:0] b_im_i,
  output logic        valid_o,
  output logic signed [15:0] r_re_o,
  output logic signed [15:0] r_im_o,
  output logic        equal_o,
  output logic        div_zero_o,
  output logic        overflow_o
);
  import cau_pkg::*;

  localparam logic [33:0] Half = (34'd1 << FRAC_BITS) >> 1;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] re;
    logic [15:0] im;
    logic        ovf;
    logic        eq;
    logic        dz;
    logic        big_re;
    logic        big_im;
    logic        neg_re;
    logic        neg_im;
  } side_t;

  assign busy = 1'b0;

  // stage 1: input register
  logic               v1_q;
  logic [2:0]         f1_q;
  logic signed [15:0] a1_q, b1_q, c1_q, d1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q <= func_i;
    a1_q <= a_re_i;
    b1_q <= a_im_i;
    c1_q <= b_re_i;
    d1_q <= b_im_i;
  end

  // stage 2: products and the simple operations
  logic               v2_q;
  logic [2:0]         f2_q;
  logic signed [31:0] ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
  logic [15:0]        sre_d, sim_d, sre_q, sim_q;
  logic               sovf_d, sovf_q, eq_q;
  sat_t               sat_re, sat_im;

  always_comb begin
    logic signed [33:0] xr, xi;
    xr = '0;
    xi = '0;
    case (f1_q)
      FUNC_ADD: begin
        xr = 34'(a1_q) + 34'(c1_q);
        xi = 34'(b1_q) + 34'(d1_q);
      end
      FUNC_SUB: begin
        xr = 34'(a1_q) - 34'(c1_q);
        xi = 34'(b1_q) - 34'(d1_q);
      end
      FUNC_NEG: begin
        xr = -34'(a1_q);
        xi = -34'(b1_q);
      end
      default: begin
        xr = '0;
        xi = '0;
      end
    endcase
    sat_re = sat16(xr);
    sat_im = sat16(xi);
    sre_d  = sat_re.val;
    sim_d  = sat_im.val;
    sovf_d = sat_re.ovf | sat_im.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f2_q   <= f1_q;
    ac_q   <= a1_q * c1_q;
    bd_q   <= b1_q * d1_q;
    ad_q   <= a1_q * d1_q;
    bc_q   <= b1_q * c1_q;
    cc_q   <= c1_q * c1_q;
    dd_q   <= d1_q * d1_q;
    sre_q  <= sre_d;
    sim_q  <= sim_d;
    sovf_q <= sovf_d;
    eq_q   <= (f1_q == FUNC_CMP) && (a1_q == c1_q) && (b1_q == d1_q);
  end

  // stage 3: sums of products and divisor
  logic               v3_q;
  logic [2:0]         f3_q;
  logic signed [32:0] mre_q, mim_q, nre_q, nim_q;
  logic [31:0]        den3_q;
  logic [15:0]        sre3_q, sim3_q;
  logic               sovf3_q, eq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f3_q    <= f2_q;
    mre_q   <= 33'(ac_q) - 33'(bd_q);
    mim_q   <= 33'(ad_q) + 33'(bc_q);
    nre_q   <= 33'(ac_q) + 33'(bd_q);
    nim_q   <= 33'(bc_q) - 33'(ad_q);
    den3_q  <= cc_q[31:0] + dd_q[31:0];
    sre3_q  <= sre_q;
    sim3_q  <= sim_q;
    sovf3_q <= sovf_q;
    eq3_q   <= eq_q;
  end

  // stage 4: multiply rounding and divider setup
  logic              v4_q;
  side_t             side4_d, side4_q;
  logic [RemW-1:0]   numre_d, numim_d, numre_q, numim_q;
  logic [31:0]       den4_q;

  always_comb begin
    logic signed [33:0] rr, ri;
    logic [32:0]        magr, magi;
    logic [RemW-1:0]    lim;
    sat_t               mr, mi;
    rr   = (34'(mre_q) + $signed(Half)) >>> FRAC_BITS;
    ri   = (34'(mim_q) + $signed(Half)) >>> FRAC_BITS;
    mr   = sat16(rr);
    mi   = sat16(ri);
    magr = nre_q[32] ? 33'(-nre_q) : 33'(nre_q);
    magi = nim_q[32] ? 33'(-nim_q) : 33'(nim_q);
    numre_d = {{(RemW-33){1'b0}}, magr} << FRAC_BITS;
    numim_d = {{(RemW-33){1'b0}}, magi} << FRAC_BITS;
    lim     = {{(RemW-32){1'b0}}, den3_q} << QuoW;

    side4_d        = '0;
    side4_d.func   = f3_q;
    side4_d.eq     = eq3_q;
    side4_d.neg_re = nre_q[32];
    side4_d.neg_im = nim_q[32];
    side4_d.big_re = numre_d >= lim;
    side4_d.big_im = numim_d >= lim;
    case (f3_q)
      FUNC_MUL: begin
        side4_d.re  = mr.val;
        side4_d.im  = mi.val;
        side4_d.ovf = mr.ovf | mi.ovf;
      end
      FUNC_DIV: begin
        side4_d.dz = (den3_q == '0);
      end
      default: begin
        side4_d.re  = sre3_q;
        side4_d.im  = sim3_q;
        side4_d.ovf = sovf3_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side4_q <= side4_d;
    numre_q <= numre_d;
    numim_q <= numim_d;
    den4_q  <= den3_q;
  end

  // divider lanes
  logic [QuoW-1:0] quo_re, quo_im;

  cau_div u_div_re (
    .clk_i (clk_i),
    .num_i (numre_q),
    .den_i (den4_q),
    .quo_o (quo_re)
  );

  cau_div u_div_im (
    .clk_i (clk_i),
    .num_i (numim_q),
    .den_i (den4_q),
    .quo_o (quo_im)
  );

  // side line alongside the divider
  logic  vl_q [DivSteps];
  side_t sl_q [DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivSteps; i++) vl_q[i] <= 1'b0;
    end else begin
      vl_q[0] <= v4_q;
      for (int i = 1; i < DivSteps; i++) vl_q[i] <= vl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sl_q[0] <= side4_q;
    for (int i = 1; i < DivSteps; i++) sl_q[i] <= sl_q[i-1];
  end

  // output stage: quotient sign and saturation, result select
  side_t       sf;
  logic [15:0] qre, qim, ore_d, oim_d;
  logic        qovre, qovim, oeq_d, odz_d, oovf_d;
  logic        vout_q;
  logic [15:0] ore_q, oim_q;
  logic        oeq_q, odz_q, oovf_q;

  function automatic logic [16:0] qsat(input logic [QuoW-1:0] q, input logic big,
                                       input logic neg);
    logic [16:0] r;
    if (!neg && (big || q > 17'd32767)) begin
      r = {1'b1, 16'h7fff};
    end else if (neg && (big || q > 17'd32768)) begin
      r = {1'b1, 16'h8000};
    end else if (neg) begin
      r = {1'b0, 16'(-q)};
    end else begin
      r = {1'b0, q[15:0]};
    end
    return r;
  endfunction

  assign sf = sl_q[DivSteps-1];

  always_comb begin
    {qovre, qre} = qsat(quo_re, sf.big_re, sf.neg_re);
    {qovim, qim} = qsat(quo_im, sf.big_im, sf.neg_im);
    ore_d  = sf.re;
    oim_d  = sf.im;
    oeq_d  = sf.eq;
    odz_d  = sf.dz;
    oovf_d = sf.ovf;
    case (sf.func) inside
      FUNC_DIV: begin
        if (sf.dz) begin
          ore_d  = '0;
          oim_d  = '0;
          oovf_d = 1'b0;
        end else begin
          ore_d  = qre;
          oim_d  = qim;
          oovf_d = qovre | qovim;
        end
      end
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_NEG: begin
        ore_d = sf.re;
      end
      default: begin
        ore_d  = '0;
        oim_d  = '0;
        oovf_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else begin
      vout_q <= vl_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ore_q  <= ore_d;
    oim_q  <= oim_d;
    oeq_q  <= oeq_d;
    odz_q  <= odz_d;
    oovf_q <= oovf_d;
  end

  assign valid_o    = vout_q;
  assign r_re_o     = ore_q;
  assign r_im_o     = oim_q;
  assign equal_o    = oeq_q;
  assign div_zero_o = odz_q;
  assign overflow_o = oovf_q;

endmodule

// ===== hw/rtl/cau_checker.sv =====
module cau_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        valid_o,
  input logic [15:0] r_re_o,
  input logic [15:0] r_im_o,
  input logic        equal_o,
  input logic        div_zero_o,
  input logic        overflow_o
);

  // pipeline never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // divide by zero word carries a zero result and no overflow
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_zero_o) |-> (r_re_o == 16'h0 && r_im_o == 16'h0 && !overflow_o
                                 && !equal_o))
    else $error("divide by zero word not cleared");

  // compare word reporting equal has zero parts and no overflow
  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && equal_o) |-> (r_re_o == 16'h0 && r_im_o == 16'h0 && !overflow_o))
    else $error("compare word not cleared");

  // overflow means some part sits at a rail
  a_ovf_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && overflow_o) |-> (r_re_o == 16'h7fff || r_re_o == 16'h8000
                                 || r_im_o == 16'h7fff || r_im_o == 16'h8000))
    else $error("overflow without saturated part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// ===== tb/complex_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int unsigned FracBits = 8;

  // one expected result word
  typedef struct {
    logic [15:0] re;
    logic [15:0] im;
    logic        eq;
    logic        dz;
    logic        ovf;
  } cplx_res_t;

  // expected results in arrival order, checked against the strobe
  class cplx_scoreboard;
    cplx_res_t pending[$];
    int errors;
    int accepted;
    int checked;

    function automatic logic [15:0] clamp(input longint x, inout logic ovf);
      if (x > 32767) begin
        ovf = 1'b1;
        return 16'h7fff;
      end
      if (x < -32768) begin
        ovf = 1'b1;
        return 16'h8000;
      end
      return x[15:0];
    endfunction

    // round to nearest, ties up, then drop the fraction
    function automatic longint round_frac(input longint x);
      longint m;
      m = longint'(1) << FracBits;
      x = x + m / 2;
      return (x - (((x % m) + m) % m)) / m;
    endfunction

    function automatic cplx_res_t compute(input logic [2:0] f,
        input logic signed [15:0] ar, ai, br, bi);
      cplx_res_t r;
      longint a, b, c, d, den;
      logic ovf;
      a = ar; b = ai; c = br; d = bi;
      ovf = 1'b0;
      r.re = '0; r.im = '0; r.eq = 1'b0; r.dz = 1'b0;
      case (f)
        FUNC_ADD: begin
          r.re = clamp(a + c, ovf);
          r.im = clamp(b + d, ovf);
        end
        FUNC_SUB: begin
          r.re = clamp(a - c, ovf);
          r.im = clamp(b - d, ovf);
        end
        FUNC_MUL: begin
          r.re = clamp(round_frac(a * c - b * d), ovf);
          r.im = clamp(round_frac(a * d + b * c), ovf);
        end
        FUNC_DIV: begin
          den = c * c + d * d;
          if (den == 0) r.dz = 1'b1;
          else begin
            r.re = clamp(((a * c + b * d) * (longint'(1) << FracBits)) / den, ovf);
            r.im = clamp(((b * c - a * d) * (longint'(1) << FracBits)) / den, ovf);
          end
        end
        FUNC_NEG: begin
          r.re = clamp(-a, ovf);
          r.im = clamp(-b, ovf);
        end
        FUNC_CMP: r.eq = (a == c) && (b == d);
        default: ;
      endcase
      r.ovf = ovf;
      return r;
    endfunction

    function void note_word(input logic [2:0] f, input logic signed [15:0] ar, ai, br, bi);
      pending.push_back(compute(f, ar, ai, br, bi));
      accepted++;
    endfunction

    function void check_word(input logic [15:0] re, im, input logic eq, dz, ovf);
      cplx_res_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (re !== e.re) begin
        $error("r_re expected %0h actual %0h", e.re, re); errors++;
      end
      if (im !== e.im) begin
        $error("r_im expected %0h actual %0h", e.im, im); errors++;
      end
      if (eq !== e.eq) begin
        $error("equal expected %0b actual %0b", e.eq, eq); errors++;
      end
      if (dz !== e.dz) begin
        $error("div_zero expected %0b actual %0b", e.dz, dz); errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflow expected %0b actual %0b", e.ovf, ovf); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func_i = '0;
  logic signed [15:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic valid_o;
  logic signed [15:0] r_re_o, r_im_o;
  logic equal_o, div_zero_o, overflow_o;

  cplx_scoreboard sb;
  int gap_words;

  complex_arithmetic_unit #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .valid_o, .r_re_o, .r_im_o, .equal_o, .div_zero_o, .overflow_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1)
      sb.check_word(r_re_o, r_im_o, equal_o, div_zero_o, overflow_o);
  end

  // drive one word and hold it until accepted
  task automatic send_word(input logic [2:0] f, input logic [15:0] ar, ai, br, bi);
    start <= 1'b1;
    func_i <= f;
    a_re_i <= ar; a_im_i <= ai; b_re_i <= br; b_im_i <= bi;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_word(f, ar, ai, br, bi);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // parts mix small magnitudes, zero, rails and full range values
  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      2: return 16'($signed($urandom_range(0, 8192)) - 4096);
      3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      4: return 16'h0000;
      default: return 16'($signed($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  initial begin
    logic [2:0] f;
    logic [15:0] ar, ai, br, bi;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, special cases
    send_word(FUNC_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    send_word(FUNC_ADD, 16'h0100, 16'h0200, 16'h0300, 16'hff00);
    send_word(FUNC_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    send_word(FUNC_SUB, 16'h0100, 16'h0100, 16'h0100, 16'h0100);
    send_word(FUNC_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    send_word(FUNC_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_word(FUNC_MUL, 16'h0080, 16'h0000, 16'h0001, 16'h0000);
    send_word(FUNC_MUL, 16'hff80, 16'h0000, 16'h0001, 16'h0000);
    send_word(FUNC_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
    send_word(FUNC_DIV, 16'h0300, 16'h0400, 16'h0100, 16'h0100);
    send_word(FUNC_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    send_word(FUNC_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    send_word(FUNC_DIV, 16'hfd00, 16'h0100, 16'h0200, 16'hff00);
    send_word(FUNC_NEG, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    send_word(FUNC_NEG, 16'h7fff, 16'h0001, 16'h0000, 16'h0000);
    send_word(FUNC_CMP, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
    send_word(FUNC_CMP, 16'h1234, 16'h8000, 16'h1234, 16'h8001);
    send_word(3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
    send_word(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

    // hold off until the pipeline has drained
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);

    // random words, idle bursts except in the last part
    for (int n = 0; n < 1400; n++) begin
      f = $urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      ar = rand_part(); ai = rand_part(); br = rand_part(); bi = rand_part();
      if (f == FUNC_CMP && $urandom_range(0, 1)) begin
        br = ar;
        if ($urandom_range(0, 2) != 0) bi = ai;
      end
      send_word(f, ar, ai, br, bi);
      if (n < 1200 && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 9));
      if (n == 700) begin
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    // drain, then let the pipeline run out
    gap_words = 0;
    while (sb.pending.size() != 0 && gap_words < 200) begin
      @(posedge clk_i);
      gap_words++;
    end
    repeat (30) @(posedge clk_i);

    $display("covered %0d words over all operations, %0d results checked",
             sb.accepted, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("complex_arithmetic_unit_test OK");
    end else begin
      $display("complex_arithmetic_unit_test NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("complex_arithmetic_unit_test NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_div.sv
hw/rtl/complex_arithmetic_unit.sv
hw/rtl/cau_checker.sv
tb/complex_arithmetic_unit_test.sv
